// ===== design/bea_pkg.sv =====
// Shared types, constants and codes for the broadcasting element-wise ALU.
package bea_pkg;
    localparam int MaxDim   = 1024;
    localparam int IdxW     = $clog2(MaxDim);
    localparam int CntW     = IdxW + 1;
    localparam int DataW    = 32;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_POW = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        BK_SAME = 2'd0,
        BK_COL  = 2'd1,
        BK_ROW  = 2'd2,
        BK_SCAL = 2'd3
    } t_bkind;

    typedef enum logic [2:0] {
        REG_OPCODE  = 3'd0,
        REG_BKIND   = 3'd1,
        REG_ROWS    = 3'd2,
        REG_COLS    = 3'd3,
        REG_REVERSE = 3'd4
    } t_reg_idx;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_OPER = 5'b00100,
        S_ITER = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    function automatic logic [CntW-1:0] clamp_count(input logic [10:0] n);
        logic [CntW-1:0] r;
        if (n == 11'd0) begin
            r = CntW'(1);
        end else if ({21'd0, n} > 32'(MaxDim)) begin
            r = CntW'(MaxDim);
        end else begin
            r = CntW'(n);
        end
        return r;
    endfunction
endpackage

// ===== design/bea_if.sv =====
// Valid/ready channel interfaces for items, results and configuration writes.
interface bea_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [9:0]  load_index;
    logic signed [31:0] stream_value;
    logic signed [31:0] other_value;
    modport source (output valid, mode, load_index, stream_value, other_value, input ready);
    modport sink   (input valid, mode, load_index, stream_value, other_value, output ready);
endinterface

interface bea_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] result;
    logic        last;
    logic        error;
    modport source (output valid, result, last, error, input ready);
    modport sink   (input valid, result, last, error, output ready);
endinterface

interface bea_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/bea_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module bea_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/broadcast_elementwise_alu_top.sv =====
// Top level of the broadcasting element-wise integer ALU.
// The block takes one item at a time. A load item writes one entry of the
// broadcast store. A compute item reads the store (registered RAM read),
// then runs its operation: add, subtract and multiply finish in the
// operation state, divide runs a restoring divider that retires one
// quotient bit per cycle, and power runs repeated squaring, one exponent
// bit per cycle, stopping when the remaining exponent is zero. The result
// sits in an output register, and the next item is accepted once that
// register has been taken. A configuration transfer to a defined register
// (index up to REG_REVERSE) restarts the matrix at row 0, column 0; the
// store is not cleared and an unwritten entry reads as an arbitrary value.
module broadcast_elementwise_alu_top (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bea_in_if.sink    in_ch,
    bea_out_if.source out_ch,
    bea_cfg_if.sink   cfg_ch
);
    import bea_pkg::*;

    logic [2:0]       r_opcode;
    logic [1:0]       r_bkind;
    logic [10:0]      r_rows;
    logic [10:0]      r_cols;
    logic             r_reverse;
    logic [IdxW-1:0]  r_row_pos, r_col_pos;
    t_state           r_state;
    logic [31:0]      r_sv, r_ov;
    logic [31:0]      r_a, r_b;        // operands, or divider remainder/divisor
    logic [31:0]      r_acc;           // quotient or power accumulator
    logic [31:0]      r_base;
    logic [5:0]       r_cnt;
    logic             r_neg;
    logic             r_last;
    logic [31:0]      r_res;
    logic             r_err;
    logic             r_out_valid;

    logic [31:0]      w_rdata;
    logic [IdxW-1:0]  w_raddr;
    logic [CntW-1:0]  w_rows, w_cols;
    logic [IdxW-1:0]  w_row_c, w_col_c;
    logic             w_in_xfer, w_cfg_xfer;
    logic [31:0]      w_bval, w_a, w_b;
    logic [32:0]      w_sub;

    assign w_rows = clamp_count(r_rows);
    assign w_cols = clamp_count(r_cols);
    // Positions are clamped to the current counts, as counts may shrink.
    assign w_row_c = ({1'b0, r_row_pos} >= w_rows) ? IdxW'(w_rows - 1'b1) : r_row_pos;
    assign w_col_c = ({1'b0, r_col_pos} >= w_cols) ? IdxW'(w_cols - 1'b1) : r_col_pos;

    assign in_ch.ready  = (r_state == S_IDLE) && !r_out_valid;
    assign cfg_ch.ready = 1'b1;
    assign w_in_xfer  = in_ch.valid && in_ch.ready;
    assign w_cfg_xfer = cfg_ch.valid && cfg_ch.ready;

    always_comb begin
        case (t_bkind'(r_bkind))
            BK_COL:  w_raddr = w_row_c;
            BK_ROW:  w_raddr = w_col_c;
            default: w_raddr = '0;
        endcase
    end

    bea_ram #(.Width(DataW), .Depth(MaxDim)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_in_xfer && !in_ch.mode),
        .i_waddr (in_ch.load_index[IdxW-1:0]),
        .i_wdata (in_ch.other_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_bval = (t_bkind'(r_bkind) == BK_SAME) ? r_ov : w_rdata;
    assign w_a    = r_reverse ? w_bval : r_sv;
    assign w_b    = r_reverse ? r_sv : w_bval;
    assign w_sub  = {1'b0, r_a[30:0], r_acc[31]} - {1'b0, r_b};

    assign out_ch.valid  = r_out_valid;
    assign out_ch.result = r_res;
    assign out_ch.last   = r_last;
    assign out_ch.error  = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_opcode    <= 3'd0;
            r_bkind     <= 2'd0;
            r_rows      <= 11'd1;
            r_cols      <= 11'd1;
            r_reverse   <= 1'b0;
            r_row_pos   <= '0;
            r_col_pos   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_xfer) begin
                case (t_reg_idx'(cfg_ch.index))
                    REG_OPCODE:  r_opcode  <= cfg_ch.data[2:0];
                    REG_BKIND:   r_bkind   <= cfg_ch.data[1:0];
                    REG_ROWS:    r_rows    <= cfg_ch.data[10:0];
                    REG_COLS:    r_cols    <= cfg_ch.data[10:0];
                    REG_REVERSE: r_reverse <= cfg_ch.data[0];
                    default: ;
                endcase
                if ({29'd0, cfg_ch.index} <= 32'(REG_REVERSE)) begin
                    r_row_pos <= '0;
                    r_col_pos <= '0;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer && in_ch.mode) begin
                        r_sv    <= in_ch.stream_value;
                        r_ov    <= in_ch.other_value;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    // Store address is presented now; data arrives next cycle.
                    r_state <= S_OPER;
                end
                S_OPER: begin
                    // Advance the row-major position.
                    if ({1'b0, w_col_c} + 1'b1 >= w_cols) begin
                        r_col_pos <= '0;
                        if ({1'b0, w_row_c} + 1'b1 >= w_rows) begin
                            r_row_pos <= '0;
                            r_last    <= 1'b1;
                        end else begin
                            r_row_pos <= w_row_c + 1'b1;
                            r_last    <= 1'b0;
                        end
                    end else begin
                        r_row_pos <= w_row_c;
                        r_col_pos <= w_col_c + 1'b1;
                        r_last    <= 1'b0;
                    end
                    case (t_opcode'(r_opcode))
                        OP_ADD: begin
                            r_res   <= w_a + w_b;
                            r_err   <= 1'b0;
                            r_state <= S_DONE;
                        end
                        OP_SUB: begin
                            r_res   <= w_a - w_b;
                            r_err   <= 1'b0;
                            r_state <= S_DONE;
                        end
                        OP_MUL: begin
                            r_res   <= w_a * w_b;
                            r_err   <= 1'b0;
                            r_state <= S_DONE;
                        end
                        OP_DIV: begin
                            if (w_b == 32'd0) begin
                                r_res   <= 32'd0;
                                r_err   <= 1'b1;
                                r_state <= S_DONE;
                            end else begin
                                r_err   <= 1'b0;
                                r_a     <= 32'd0;
                                r_acc   <= w_a[31] ? (32'd0 - w_a) : w_a;
                                r_b     <= w_b[31] ? (32'd0 - w_b) : w_b;
                                r_neg   <= w_a[31] ^ w_b[31];
                                r_cnt   <= 6'd32;
                                r_state <= S_ITER;
                            end
                        end
                        OP_POW: begin
                            if (w_b[31]) begin
                                // A negative exponent only survives for bases one
                                // and minus one; zero as the base is an error.
                                r_state <= S_DONE;
                                r_err   <= (w_a == 32'd0);
                                if (w_a == 32'd1) begin
                                    r_res <= 32'd1;
                                end else if (w_a == 32'hFFFF_FFFF) begin
                                    r_res <= w_b[0] ? 32'hFFFF_FFFF : 32'd1;
                                end else begin
                                    r_res <= 32'd0;
                                end
                            end else begin
                                r_err   <= 1'b0;
                                r_acc   <= 32'd1;
                                r_base  <= w_a;
                                r_b     <= w_b;
                                r_cnt   <= 6'd0;
                                r_state <= S_ITER;
                            end
                        end
                        default: begin
                            r_res   <= 32'd0;
                            r_err   <= 1'b0;
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_ITER: begin
                    if (t_opcode'(r_opcode) == OP_DIV) begin
                        // One restoring division step per cycle.
                        if (!w_sub[32]) begin
                            r_a   <= w_sub[31:0];
                            r_acc <= {r_acc[30:0], 1'b1};
                        end else begin
                            r_a   <= {r_a[30:0], r_acc[31]};
                            r_acc <= {r_acc[30:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 1'b1;
                        if (r_cnt == 6'd1) begin
                            r_state <= S_DONE;
                            if (!w_sub[32]) begin
                                r_res <= r_neg ? 32'd0 - {r_acc[30:0], 1'b1}
                                               : {r_acc[30:0], 1'b1};
                            end else begin
                                r_res <= r_neg ? 32'd0 - {r_acc[30:0], 1'b0}
                                               : {r_acc[30:0], 1'b0};
                            end
                        end
                    end else begin
                        // One exponent bit per cycle: multiply, then square.
                        if (r_b == 32'd0) begin
                            r_res   <= r_acc;
                            r_state <= S_DONE;
                        end else begin
                            if (r_b[0]) begin
                                r_acc <= r_acc * r_base;
                            end
                            r_base <= r_base * r_base;
                            r_b    <= r_b >> 1;
                        end
                    end
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/bea_checker.sv =====
// Port-level checker for the broadcasting element-wise ALU, bound to the top.
module bea_props (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_mode,
    input logic out_valid,
    input logic out_ready,
    input logic out_error,
    input logic [31:0] out_result
);
    // A loaded item never yields a result right after its transfer.
    ap_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready && !in_mode && !out_valid) |=> !out_valid)
        else $error("load produced a result");
    // Input is not taken while a result waits.
    ap_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while result pending");
    // An error result always carries zero.
    ap_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && out_error) |-> (out_result == 32'd0))
        else $error("error result not zero");
    // Held results stay stable.
    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_result)))
        else $error("result changed while stalled");
endmodule

bind broadcast_elementwise_alu_top bea_props u_bea_props (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_mode    (in_ch.mode),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_error  (out_ch.error),
    .out_result (out_ch.result)
);

// ===== verif/bea_checker.sv =====
// Result checker for the broadcasting element-wise ALU: tracks its state and compares results.
module bea_checker
    import bea_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bea_in_if    in_ch,
    bea_out_if   out_ch,
    bea_cfg_if   cfg_ch,
    output int   o_fail_count,
    output int   o_pending
);
    typedef struct packed {
        logic [31:0] result;
        logic        last;
        logic        error;
    } t_elem_result;

    logic [31:0]    operand_store [MaxDim];
    logic [2:0]     op_sel;
    t_bkind         bcast_kind;
    logic [10:0]    rows_reg;
    logic [10:0]    cols_reg;
    logic           reversed;
    int unsigned    row_pos;
    int unsigned    col_pos;
    t_elem_result   expected_results [$];
    int             fails;

    function automatic logic [31:0] magnitude(logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic logic [31:0] quotient(logic [31:0] a, logic [31:0] b, output logic err);
        logic [31:0] q;
        err = 1'b0;
        if (b == 32'd0) begin
            err = 1'b1;
            return 32'd0;
        end
        q = magnitude(a) / magnitude(b);
        return (a[31] ^ b[31]) ? (32'd0 - q) : q;
    endfunction

    function automatic logic [31:0] int_power(logic [31:0] base, logic [31:0] ex,
                                              output logic err);
        logic [31:0] acc;
        acc = 32'd1;
        err = 1'b0;
        if (ex[31]) begin
            if (base == 32'd1) return 32'd1;
            if (base == 32'hFFFF_FFFF) return ex[0] ? 32'hFFFF_FFFF : 32'd1;
            if (base == 32'd0) err = 1'b1;
            return 32'd0;
        end
        while (ex != 32'd0) begin
            if (ex[0]) acc = acc * base;
            base = base * base;
            ex = ex >> 1;
        end
        return acc;
    endfunction

    // Works out the result of one compute transfer and advances the position.
    function automatic t_elem_result predict_element(logic [31:0] sv, logic [31:0] ov);
        t_elem_result r;
        int unsigned  rows;
        int unsigned  cols;
        logic [31:0]  bval;
        logic [31:0]  a;
        logic [31:0]  b;
        logic         err;
        rows = clamp_count(rows_reg);
        cols = clamp_count(cols_reg);
        if (row_pos >= rows) row_pos = rows - 1;
        if (col_pos >= cols) col_pos = cols - 1;
        case (bcast_kind)
            BK_SAME: bval = ov;
            BK_COL:  bval = operand_store[row_pos];
            BK_ROW:  bval = operand_store[col_pos];
            default: bval = operand_store[0];
        endcase
        a = reversed ? bval : sv;
        b = reversed ? sv : bval;
        err = 1'b0;
        case (op_sel)
            OP_ADD:  r.result = a + b;
            OP_SUB:  r.result = a - b;
            OP_MUL:  r.result = a * b;
            OP_DIV:  r.result = quotient(a, b, err);
            OP_POW:  r.result = int_power(a, b, err);
            default: r.result = 32'd0;
        endcase
        r.error = err;
        r.last = 1'b0;
        if (col_pos + 1 >= cols) begin
            col_pos = 0;
            if (row_pos + 1 >= rows) begin
                row_pos = 0;
                r.last = 1'b1;
            end else begin
                row_pos++;
            end
        end else begin
            col_pos++;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_elem_result got;
        t_elem_result want;
        if (!i_rst_n) begin
            op_sel = OP_ADD;
            bcast_kind = BK_SAME;
            rows_reg = 11'd1;
            cols_reg = 11'd1;
            reversed = 1'b0;
            row_pos = 0;
            col_pos = 0;
            expected_results.delete();
            fails = 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (t_reg_idx'(cfg_ch.index))
                    REG_OPCODE:  op_sel = cfg_ch.data[2:0];
                    REG_BKIND:   bcast_kind = t_bkind'(cfg_ch.data[1:0]);
                    REG_ROWS:    rows_reg = cfg_ch.data[10:0];
                    REG_COLS:    cols_reg = cfg_ch.data[10:0];
                    REG_REVERSE: reversed = cfg_ch.data[0];
                    default:     ;
                endcase
                // Only a write to a defined register restarts the matrix.
                if (cfg_ch.index <= REG_REVERSE) begin
                    row_pos = 0;
                    col_pos = 0;
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                if (!in_ch.mode) operand_store[in_ch.load_index] = in_ch.other_value;
                else expected_results.push_back(predict_element(in_ch.stream_value,
                                                                in_ch.other_value));
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.result, out_ch.last, out_ch.error};
                if (expected_results.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result transfer: result %h last %b error %b",
                                 got.result, got.last, got.error);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: expected result %h last %b error %b, got %h %b %b",
                                     want.result, want.last, want.error,
                                     got.result, got.last, got.error);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending <= expected_results.size();
    end
endmodule

// ===== verif/tb.sv =====
// Top of the testbench for the broadcasting element-wise ALU: stimulus, idling and verdict.
module tb;
    import bea_pkg::*;

    // Register index past the defined list; a write there must change nothing.
    localparam logic [2:0] RegUnused = 3'd6;
    // Opcodes past the defined list give zero results.
    localparam logic [2:0] OpUnusedLo = 3'd5;
    localparam logic [2:0] OpUnusedHi = 3'd7;
    localparam int LongHold = 300;
    localparam int IdleLimit = 3000;
    localparam int DrainCycles = 60;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;

    bea_in_if  in_ch ();
    bea_out_if out_ch ();
    bea_cfg_if cfg_ch ();

    broadcast_elementwise_alu_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch)
    );

    bea_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // When quiet is set, neither side inserts gaps. Bumping hold_req asks the
    // result side for one long stall while the item side keeps offering.
    bit quiet;
    int hold_req;
    int hold_seen;
    int ready_gap;

    // Shadow of the matrix walk, kept only so that the stimulus can load any
    // store entry before a compute transfer reads it.
    bit          entry_loaded [MaxDim];
    t_bkind      cur_kind;
    int unsigned cur_rows;
    int unsigned cur_cols;
    int unsigned walk_row;
    int unsigned walk_col;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            5, 6: return 32'($signed($urandom_range(0, 40)) - 20);
            default: return $urandom;
        endcase
    endfunction

    // The result side stalls at random, with one long stall on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            ready_gap <= 0;
            hold_seen <= 0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            ready_gap <= LongHold;
            out_ch.ready <= 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap <= ready_gap - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            ready_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        end
    end

    // Watchdog: the run ends if no transfer happens for too long.
    int idle_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("broadcast_elementwise_alu_top test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(logic mode, logic [9:0] idx, logic [31:0] sv, logic [31:0] ov);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= mode;
        in_ch.load_index <= idx;
        in_ch.stream_value <= sv;
        in_ch.other_value <= ov;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic load_entry(logic [9:0] idx, logic [31:0] val);
        send_item(1'b0, idx, $urandom, val);
        entry_loaded[idx] = 1'b1;
    endtask

    // Sends one compute transfer, loading the entry it reads first if needed.
    task automatic compute(logic [31:0] sv, logic [31:0] ov);
        int unsigned need;
        if (walk_row >= cur_rows) walk_row = cur_rows - 1;
        if (walk_col >= cur_cols) walk_col = cur_cols - 1;
        need = (cur_kind == BK_COL) ? walk_row : (cur_kind == BK_ROW) ? walk_col : 0;
        if (cur_kind != BK_SAME && !entry_loaded[need]) load_entry(need[9:0], pick_operand());
        send_item(1'b1, 10'($urandom), sv, ov);
        if (walk_col + 1 >= cur_cols) begin
            walk_col = 0;
            walk_row = (walk_row + 1 >= cur_rows) ? 0 : walk_row + 1;
        end else begin
            walk_col++;
        end
    endtask

    // Configuration is written only once the block has gone quiet.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        case (t_reg_idx'(idx))
            REG_BKIND: cur_kind = t_bkind'(val[1:0]);
            REG_ROWS:  cur_rows = clamp_count(val[10:0]);
            REG_COLS:  cur_cols = clamp_count(val[10:0]);
            default:   ;
        endcase
        if (idx <= REG_REVERSE) begin
            walk_row = 0;
            walk_col = 0;
        end
    endtask

    task automatic setup(logic [2:0] op, t_bkind kind, logic [10:0] rows, logic [10:0] cols,
                         logic rev);
        wait_idle();
        write_reg(REG_OPCODE, {29'($urandom), op});
        write_reg(REG_BKIND, {30'($urandom), kind});
        write_reg(REG_ROWS, {21'($urandom), rows});
        write_reg(REG_COLS, {21'($urandom), cols});
        write_reg(REG_REVERSE, {31'($urandom), rev});
    endtask

    function automatic logic [10:0] pick_count();
        case ($urandom_range(0, 19))
            0: return 11'd0;
            1: return 11'd1024;
            2: return 11'd2047;
            default: return 11'($urandom_range(1, 6));
        endcase
    endfunction

    initial begin
        int n;
        logic [10:0] rows;
        logic [10:0] cols;
        i_rst_n = 1'b0;
        quiet = 1'b0;
        hold_req = 0;
        in_ch.valid = 1'b0;
        in_ch.mode = 1'b0;
        in_ch.load_index = '0;
        in_ch.stream_value = '0;
        in_ch.other_value = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        cur_kind = BK_SAME;
        cur_rows = 1;
        cur_cols = 1;
        walk_row = 0;
        walk_col = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on a same-shape stream; a zero row count acts as one
        // and an oversized column count acts as the maximum.
        setup(OP_ADD, BK_SAME, 11'd0, 11'd2047, 1'b0);
        compute(32'h7FFF_FFFF, 32'd1);
        compute(32'h8000_0000, 32'hFFFF_FFFF);
        setup(OP_SUB, BK_SAME, 11'd2, 11'd2, 1'b1);
        compute(32'h8000_0000, 32'd1);
        compute(32'd5, 32'd9);
        setup(OP_MUL, BK_SAME, 11'd1, 11'd3, 1'b0);
        compute(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        compute(32'h8000_0000, 32'hFFFF_FFFF);
        compute(32'hFFFF_FFF9, 32'd6);
        setup(OP_DIV, BK_SAME, 11'd1, 11'd1, 1'b0);
        compute(32'd17, 32'd0);                     // divide by zero
        compute(32'h8000_0000, 32'hFFFF_FFFF);      // most negative over minus one
        compute(32'hFFFF_FFF9, 32'd2);              // truncation toward zero
        setup(OP_POW, BK_SAME, 11'd1, 11'd1, 1'b0);
        compute(32'd1, 32'hFFFF_FFFD);              // base one, negative exponent
        compute(32'hFFFF_FFFF, 32'hFFFF_FFFD);      // base minus one, odd negative
        compute(32'hFFFF_FFFF, 32'hFFFF_FFFE);      // base minus one, even negative
        compute(32'd0, 32'hFFFF_FFFF);              // zero to a negative power
        compute(32'd7, 32'h8000_0000);              // other base, negative power
        compute(32'd0, 32'd0);                      // zero to the zero
        compute(32'd3, 32'h7FFF_FFFF);
        setup(OpUnusedLo, BK_SAME, 11'd1, 11'd1, 1'b0);
        compute(32'd3, 32'd4);
        setup(OpUnusedHi, BK_SCAL, 11'd1, 11'd2, 1'b1);
        load_entry(10'd1023, 32'hDEAD_BEEF);
        load_entry(10'd0, 32'd0);
        compute(32'd3, 32'd4);
        // A write to an undefined register index must not restart the walk.
        wait_idle();
        write_reg(RegUnused, $urandom);
        compute(32'd8, 32'd9);

        // Random phases with random configurations.
        n = 0;
        while (n < 700) begin
            rows = pick_count();
            cols = pick_count();
            setup(3'($urandom_range(0, 9) < 9 ? $urandom_range(0, 4) : $urandom_range(5, 7)),
                  t_bkind'($urandom_range(0, 3)), rows, cols, 1'($urandom));
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0) hold_req = hold_req + 1;
            repeat ($urandom_range(20, 60)) begin
                if ($urandom_range(0, 5) == 0) begin
                    load_entry(10'($urandom_range(0, 1023)), pick_operand());
                end else begin
                    compute(pick_operand(), pick_operand());
                end
                n++;
            end
            quiet = 1'b0;
        end
        // Guaranteed long stall on the result side while items keep coming.
        hold_req = hold_req + 1;
        repeat (20) compute(pick_operand(), pick_operand());
        in_ch.valid <= 1'b0;

        n = 0;
        @(posedge i_clk);
        while (pending != 0 && n < 20 * IdleLimit) begin
            @(posedge i_clk);
            n++;
        end
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("broadcast_elementwise_alu_top test passed");
        end else begin
            $display("broadcast_elementwise_alu_top test failed");
        end
        $finish;
    end
endmodule

// ===== broadcast_elementwise_alu_top.f =====
design/bea_pkg.sv
design/bea_if.sv
design/bea_ram.sv
design/broadcast_elementwise_alu_top.sv
design/bea_checker.sv
verif/bea_checker.sv
verif/tb.sv
